// ===== rtl/psg_pkg.sv =====
`timescale 1ns / 1ps

package psg_pkg;

   localparam logic [2:0] SEL_TONE_0  = 3'd0;
   localparam logic [2:0] SEL_ATTEN_0 = 3'd1;
   localparam logic [2:0] SEL_TONE_1  = 3'd2;
   localparam logic [2:0] SEL_ATTEN_1 = 3'd3;
   localparam logic [2:0] SEL_TONE_2  = 3'd4;
   localparam logic [2:0] SEL_ATTEN_2 = 3'd5;
   localparam logic [2:0] SEL_NOISE   = 3'd6;
   localparam logic [2:0] SEL_ATTEN_3 = 3'd7;

   localparam logic [3:0] ATTEN_SILENT = 4'd15;

   typedef struct packed {
      logic [2:0][9:0] period;
      logic [3:0][3:0] atten;
      logic [2:0]      noise_bits;
      logic            noise_restart;
   } regs_type;

   typedef struct packed {
      logic [3:0] tone_sign;
      logic [3:0] atten_0;
      logic [3:0] atten_1;
      logic [3:0] atten_2;
      logic [3:0] atten_3;
      logic [2:0] noise_control;
      logic       noise_trigger;
   } result_type;

endpackage

// ===== rtl/psg_core.sv =====
`timescale 1ns / 1ps

module psg_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   write_valid,
   input  logic [7:0]             write_data,
   input  logic                   reset_line,
   output psg_pkg::result_type    result
);

   logic              pa_ff, pa_in;
   logic              pb_ff, pb_in;
   logic [1:0]        cha_ff, cha_in;
   logic [1:0]        chb_ff, chb_in;
   logic [7:0]        bus_ff, bus_in;
   logic              seen_ff, seen_in;
   logic [2:0]        sel_ff, sel_in;
   psg_pkg::regs_type regs_ff, regs_in;
   logic              rseen_ff, rseen_in;
   logic [2:0]        oh_ff, oh_in;
   logic [1:0]        slot_ff, slot_in;
   logic [3:0][9:0]   count_ff, count_in;
   logic [3:0]        ovf_ff, ovf_in;
   logic [3:0]        sign_ff, sign_in;
   logic              mask_ff, mask_in;
   logic              force_ff, force_in;

   function automatic logic pick(logic frc, logic seen, logic [2:0] sel, logic [2:0] code);
      pick = frc | (seen && (sel == code));
   endfunction

   function automatic logic [9:0] set_period(logic [9:0] p, logic frc, logic [7:0] d);
      logic [9:0] v;
      v = p;
      if (d[7] || frc) v = {v[9:4], d[3:0]};
      if (!d[7]) v = {d[5:0], v[3:0]};
      set_period = v;
   endfunction

   function automatic psg_pkg::regs_type apply_write(
      psg_pkg::regs_type r, logic frc, logic msk, logic seen, logic [2:0] sel, logic [7:0] d);
      psg_pkg::regs_type v;
      logic [3:0]        a;
      v = r;
      a = msk ? psg_pkg::ATTEN_SILENT : d[3:0];
      if (pick(frc, seen, sel, psg_pkg::SEL_ATTEN_0)) v.atten[0] = a;
      if (pick(frc, seen, sel, psg_pkg::SEL_ATTEN_1)) v.atten[1] = a;
      if (pick(frc, seen, sel, psg_pkg::SEL_ATTEN_2)) v.atten[2] = a;
      if (pick(frc, seen, sel, psg_pkg::SEL_ATTEN_3)) v.atten[3] = a;
      if (pick(frc, seen, sel, psg_pkg::SEL_TONE_0))
         v.period[0] = set_period(v.period[0], frc, d);
      if (pick(frc, seen, sel, psg_pkg::SEL_TONE_1))
         v.period[1] = set_period(v.period[1], frc, d);
      if (pick(frc, seen, sel, psg_pkg::SEL_TONE_2))
         v.period[2] = set_period(v.period[2], frc, d);
      if (pick(frc, seen, sel, psg_pkg::SEL_NOISE)) begin
         v.noise_bits    = d[2:0];
         v.noise_restart = 1'b1;
      end
      apply_write = v;
   endfunction

   logic              phase_one, phase_two;
   logic [7:0]        vis1, vis2;
   psg_pkg::regs_type regs1, regs2;
   logic [9:0]        limit, cnt;

   always_comb begin
      bus_in = write_valid ? write_data : bus_ff;
      pa_in  = ~pa_ff;
      pb_in  = pb_ff ^ pa_ff;
      if (cha_ff == 2'b10) begin
         pa_in = 1'b0;
         pb_in = 1'b0;
      end
      cha_in = {cha_ff[0], reset_line};

      vis1  = mask_ff ? 8'd0 : bus_in;
      regs1 = apply_write(regs_ff, force_ff, mask_ff, seen_ff, sel_ff, vis1);
      seen_in = write_valid;
      sel_in  = (write_valid && vis1[7]) ? vis1[6:4] : sel_ff;

      phase_one = pa_in & ~pb_ff;
      phase_two = pa_in & pb_ff;

      regs_in  = regs1;
      rseen_in = rseen_ff;
      oh_in    = oh_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      sign_in  = sign_ff;
      chb_in   = chb_ff;
      mask_in  = mask_ff;
      force_in = force_ff;
      vis2     = 8'd0;
      regs2    = regs1;

      limit = 10'd0;
      if (oh_ff[0]) limit = limit | regs1.period[0];
      if (oh_ff[1]) limit = limit | regs1.period[1];
      if (oh_ff[2]) limit = limit | regs1.period[2];
      cnt = (count_ff[slot_ff] >= limit) ? 10'd0 : count_ff[slot_ff];
      if (chb_ff[1]) cnt = 10'd0;

      if (phase_one) begin
         if (oh_ff[0]) sign_in = sign_ff ^ ovf_ff;
         if (chb_ff[1]) sign_in = 4'd0;
         ovf_in = {ovf_ff[2:0], count_ff[slot_ff] >= limit};
         count_in[slot_ff] = cnt + 10'd1;
         if (chb_ff[0] || (oh_ff != 3'd0)) oh_in = {oh_ff[1:0], 1'b0};
         else oh_in = 3'd1;
         chb_in   = {chb_ff[0], reset_line};
         rseen_in = regs1.noise_restart;
      end else if (phase_two) begin
         mask_in = chb_ff[1];
         force_in = chb_ff[0];
         if (rseen_ff) regs2.noise_restart = 1'b0;
         vis2 = chb_ff[1] ? 8'd0 : bus_in;
         regs_in = apply_write(regs2, chb_ff[0], chb_ff[1], seen_in, sel_in, vis2);
         slot_in = slot_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_ff    <= 1'b0;
         pb_ff    <= 1'b0;
         cha_ff   <= '0;
         chb_ff   <= '0;
         bus_ff   <= '0;
         seen_ff  <= 1'b0;
         sel_ff   <= '0;
         regs_ff  <= '0;
         rseen_ff <= 1'b0;
         oh_ff    <= '0;
         slot_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= '0;
         sign_ff  <= '0;
         mask_ff  <= 1'b0;
         force_ff <= 1'b0;
      end else if (accept) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         cha_ff   <= cha_in;
         chb_ff   <= chb_in;
         bus_ff   <= bus_in;
         seen_ff  <= seen_in;
         sel_ff   <= sel_in;
         regs_ff  <= regs_in;
         rseen_ff <= rseen_in;
         oh_ff    <= oh_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sign_ff  <= sign_in;
         mask_ff  <= mask_in;
         force_ff <= force_in;
      end
   end

   assign result.tone_sign     = sign_in;
   assign result.atten_0       = regs_in.atten[0];
   assign result.atten_1       = regs_in.atten[1];
   assign result.atten_2       = regs_in.atten[2];
   assign result.atten_3       = regs_in.atten[3];
   assign result.noise_control = regs_in.noise_bits;
   assign result.noise_trigger = regs_in.noise_restart;

endmodule

// ===== rtl/psg_rsp_buf.sv =====
`timescale 1ns / 1ps

module psg_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  psg_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output psg_pkg::result_type rsp_data
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   psg_pkg::result_type out_ff, out_in;
   psg_pkg::result_type skid_ff, skid_in;
   logic                take;

   assign take = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/psg_register_and_tone_counter_tick.sv =====
`timescale 1ns / 1ps

// Tick-level sound generator register file and tone counters. Each request is
// one master-clock tick (optional bus byte plus clear-pin level); one response
// per request carries the sign flip-flops, attenuations and noise control as
// they stand after that tick. A request is taken every cycle unless req_stall
// is high; its response comes from a single state-update stage and is
// registered into a two-entry output buffer. req_stall rises only when both
// buffer entries hold responses not yet taken.
module psg_register_and_tone_counter_tick (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_write_valid,
   input  logic [7:0] req_write_data,
   input  logic       req_reset_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_tone_sign,
   output logic [3:0] rsp_atten_0,
   output logic [3:0] rsp_atten_1,
   output logic [3:0] rsp_atten_2,
   output logic [3:0] rsp_atten_3,
   output logic [2:0] rsp_noise_control,
   output logic       rsp_noise_trigger
);

   logic                accept;
   psg_pkg::result_type result;
   psg_pkg::result_type rsp_data;

   assign accept = req_valid & ~req_stall;

   psg_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .write_valid (req_write_valid),
      .write_data  (req_write_data),
      .reset_line  (req_reset_line),
      .result      (result)
   );

   psg_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_tone_sign     = rsp_data.tone_sign;
   assign rsp_atten_0       = rsp_data.atten_0;
   assign rsp_atten_1       = rsp_data.atten_1;
   assign rsp_atten_2       = rsp_data.atten_2;
   assign rsp_atten_3       = rsp_data.atten_3;
   assign rsp_noise_control = rsp_data.noise_control;
   assign rsp_noise_trigger = rsp_data.noise_trigger;

endmodule
